>>> rtl/linear_blend_skinning_unit_macros.svh
// ----------------------------------------------------------------------------
// Linear blend skinning unit assertion macros
// Shared assertion forms for the skinning unit's checkers.
// ----------------------------------------------------------------------------
`ifndef LINEAR_BLEND_SKINNING_UNIT_MACROS_SVH
`define LINEAR_BLEND_SKINNING_UNIT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define LBS_ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define LBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared widths, codes and types of the linear blend skinning unit.
// ----------------------------------------------------------------------------
package lbs_pkg;

  // Default palette geometry.
  localparam int JOINTS_DEF = 64;
  localparam int FRAMES_DEF = 64;

  // Field widths of the command and result ports.
  localparam int JOINT_W  = 6;
  localparam int FRAME_W  = 6;
  localparam int ELEM_W   = 4;
  localparam int DATA_W   = 32;
  localparam int WEIGHT_W = 17;

  // Datapath widths.
  localparam int COMP_W   = 48;
  localparam int ACC_W    = 82;
  localparam int MUL_A_W  = 32;
  localparam int MUL_B_W  = 25;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int KIDX_W   = 4;
  localparam int NUM_COMP = 12;

  // One in Q16.16, the implicit fourth coordinate of a vertex.
  localparam logic signed [MUL_A_W-1:0] ONE_Q16 = 32'sd65536;

  // Sequencer end points.
  localparam logic [1:0]        LAST_COL   = 2'd2;
  localparam logic [1:0]        LAST_COMP  = 2'd2;
  localparam logic [KIDX_W-1:0] LAST_K     = 4'd11;
  localparam logic [2:0]        LAST_XSTEP = 3'd7;

  // Command codes.
  typedef enum logic [0:0] {
    FUNC_WRITE = 1'b0,
    FUNC_INFL  = 1'b1
  } func_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_INFL   = 5'b00010,
    ST_IDRAIN = 5'b00100,
    ST_XFORM  = 5'b01000,
    ST_XDRAIN = 5'b10000
  } state_t;

  // Tag that travels with each product through the shared multiplier.
  typedef struct packed {
    logic              xform;
    logic [KIDX_W-1:0] idx;
    logic [1:0]        comp;
    logic              hi;
    logic              first;
    logic              last;
  } mul_tag_t;

endpackage

>>> rtl/lbs_pal_mem.sv
// ----------------------------------------------------------------------------
// lbs_pal_mem
// Joint matrix palette: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lbs_pal_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [lbs_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [lbs_pkg::DATA_W-1:0] rdata
);
  import lbs_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/lbs_mul.sv
// ----------------------------------------------------------------------------
// lbs_mul
// Shared signed multiplier with a registered product and a tag pipeline.
// ----------------------------------------------------------------------------
module lbs_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  logic signed [lbs_pkg::MUL_A_W-1:0] a,
  input  logic signed [lbs_pkg::MUL_B_W-1:0] b,
  input  lbs_pkg::mul_tag_t                  in_tag,
  output logic                               out_vld,
  output logic signed [lbs_pkg::MUL_P_W-1:0] prod,
  output lbs_pkg::mul_tag_t                  out_tag
);
  import lbs_pkg::*;

  logic                      vld_r;
  logic signed [MUL_P_W-1:0] prod_r;
  mul_tag_t                  tag_r;

  // Valid flag of the product stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // Product and its tag.
  always_ff @(posedge clk) begin
    if (in_vld) begin
      prod_r <= MUL_P_W'(a) * MUL_P_W'(b);
      tag_r  <= in_tag;
    end
  end

  assign out_vld = vld_r;
  assign prod    = prod_r;
  assign out_tag = tag_r;

endmodule

>>> rtl/linear_blend_skinning_unit.sv
// ----------------------------------------------------------------------------
// linear_blend_skinning_unit
// Palette write: busy stays low. Influence: twelve palette reads through the
// single memory read port and the shared multiplier. Last influence: 24 more
// products through the same multiplier; busy falls in the cycle after the
// strobe, and nothing stalls it.
// Synchronous reset clears the sequencer, frame register and composite.
// ----------------------------------------------------------------------------
module linear_blend_skinning_unit #(
  parameter int JOINTS = lbs_pkg::JOINTS_DEF,
  parameter int FRAMES = lbs_pkg::FRAMES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Command channel.
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_func,
  input  logic [lbs_pkg::JOINT_W-1:0]         in_joint,
  input  logic [lbs_pkg::FRAME_W-1:0]         in_frame,
  input  logic [lbs_pkg::ELEM_W-1:0]          in_element,
  input  logic signed [lbs_pkg::DATA_W-1:0]   in_value,
  input  logic [lbs_pkg::WEIGHT_W-1:0]        in_weight,
  input  logic                                in_last_influence,
  input  logic signed [lbs_pkg::DATA_W-1:0]   in_pos_x,
  input  logic signed [lbs_pkg::DATA_W-1:0]   in_pos_y,
  input  logic signed [lbs_pkg::DATA_W-1:0]   in_pos_z,
  // Result channel.
  output logic                                out_valid,
  output logic signed [lbs_pkg::DATA_W-1:0]   out_x,
  output logic signed [lbs_pkg::DATA_W-1:0]   out_y,
  output logic signed [lbs_pkg::DATA_W-1:0]   out_z,
  // Configuration port.
  input  logic                                cfg_we,
  input  logic [lbs_pkg::FRAME_W-1:0]         cfg_wdata
);
  import lbs_pkg::*;

  localparam int JF    = JOINTS * FRAMES;
  localparam int RW    = (JF > 1) ? $clog2(JF) : 1;
  localparam int AW    = RW + ELEM_W;
  localparam int DEPTH = JF * 16;

  // Sequencer and counters.
  state_t            state_r, state_nxt;
  logic [1:0]        ir_r, ir_nxt;
  logic [1:0]        ic_r, ic_nxt;
  logic [KIDX_W-1:0] ik_r, ik_nxt;
  logic [1:0]        xc_r, xc_nxt;
  logic [2:0]        xj_r, xj_nxt;
  logic              clear_comp;

  // Transaction payload held for the vertex.
  logic [FRAME_W-1:0]        cur_frame_r;
  logic [WEIGHT_W-1:0]       weight_r;
  logic                      last_r;
  logic signed [DATA_W-1:0]  pos_r [3];
  logic [RW-1:0]             base_r;

  // Composite matrix, rows 0..3 by columns 0..2.
  logic signed [COMP_W-1:0]  comp_r [NUM_COMP];

  logic accept, accept_inf, accept_wr, wr_ok, inf_ok;
  logic [RW-1:0] row_w, row_i;

  // Memory and multiplier interface.
  logic [DATA_W-1:0]         rdata;
  logic [AW-1:0]             raddr;
  logic                      rd_vld_r;
  logic [KIDX_W-1:0]         rd_k_r;
  logic                      mul_in_vld, mul_vld;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  mul_tag_t                  mul_in_tag, mul_tag;
  logic signed [MUL_P_W-1:0] mul_p;

  // Transform path.
  logic [1:0]                xr;
  logic [KIDX_W-1:0]         x_idx, comp_ridx;
  logic signed [COMP_W-1:0]  comp_rd;
  logic signed [MUL_A_W-1:0] x_pos;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt, term;
  logic                      fin_r;
  logic [1:0]                fin_comp_r;
  logic                      out_vld_r;
  logic signed [DATA_W-1:0]  out_r [3];
  logic                      pipe_busy;

  // Influence accumulate path.
  logic signed [COMP_W+1:0]  inf_sum;
  logic signed [COMP_W-1:0]  inf_sat;

  // Saturate a transform sum, taken down by 2^16, to Q16.16.
  function automatic logic signed [DATA_W-1:0] sat_q16(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DATA_W-16:0] top;
    top = v[ACC_W-1:DATA_W+15];
    if ((&top) || !(|top)) begin
      return v[DATA_W+15:16];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // Command decode.
  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign accept_wr  = accept && (in_func == FUNC_WRITE);
  assign accept_inf = accept && (in_func == FUNC_INFL);
  assign wr_ok      = (32'(in_joint) < JOINTS) && (32'(in_frame) < FRAMES);
  assign inf_ok     = (32'(in_joint) < JOINTS) && (32'(cur_frame_r) < FRAMES);
  assign row_w      = RW'(32'(in_joint) * 32'(FRAMES) + 32'(in_frame));
  assign row_i      = RW'(32'(in_joint) * 32'(FRAMES) + 32'(cur_frame_r));

  // Frame register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_frame_r <= '0;
    end else if (cfg_we) begin
      cur_frame_r <= cfg_wdata;
    end
  end

  // Palette memory.
  assign raddr = {base_r, ir_r, ic_r};

  lbs_pal_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_pal (
    .clk   (clk),
    .we    (accept_wr && wr_ok),
    .waddr ({row_w, in_element}),
    .wdata (in_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt  = state_r;
    ir_nxt     = ir_r;
    ic_nxt     = ic_r;
    ik_nxt     = ik_r;
    xc_nxt     = xc_r;
    xj_nxt     = xj_r;
    clear_comp = 1'b0;
    case (state_r)
      ST_IDLE: begin
        ir_nxt = '0;
        ic_nxt = '0;
        ik_nxt = '0;
        xc_nxt = '0;
        xj_nxt = '0;
        if (accept_inf) begin
          if (inf_ok) begin
            state_nxt = ST_INFL;
          end else if (in_last_influence) begin
            state_nxt = ST_XFORM;
          end
        end
      end
      ST_INFL: begin
        ik_nxt = ik_r + 1'b1;
        if (ic_r == LAST_COL) begin
          ic_nxt = '0;
          ir_nxt = ir_r + 1'b1;
        end else begin
          ic_nxt = ic_r + 1'b1;
        end
        if (ik_r == LAST_K) begin
          state_nxt = ST_IDRAIN;
        end
      end
      ST_IDRAIN: begin
        xc_nxt = '0;
        xj_nxt = '0;
        if (!pipe_busy) begin
          state_nxt = last_r ? ST_XFORM : ST_IDLE;
        end
      end
      ST_XFORM: begin
        xj_nxt = xj_r + 1'b1;
        if (xj_r == LAST_XSTEP) begin
          xc_nxt = xc_r + 1'b1;
          if (xc_r == LAST_COMP) begin
            state_nxt = ST_XDRAIN;
          end
        end
      end
      ST_XDRAIN: begin
        if (!pipe_busy) begin
          state_nxt  = ST_IDLE;
          clear_comp = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ir_r    <= '0;
      ic_r    <= '0;
      ik_r    <= '0;
      xc_r    <= '0;
      xj_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ir_r    <= ir_nxt;
      ic_r    <= ic_nxt;
      ik_r    <= ik_nxt;
      xc_r    <= xc_nxt;
      xj_r    <= xj_nxt;
    end
  end

  // Vertex payload captured with the influence transaction.
  always_ff @(posedge clk) begin
    if (accept_inf) begin
      weight_r <= in_weight;
      last_r   <= in_last_influence;
      pos_r[0] <= in_pos_x;
      pos_r[1] <= in_pos_y;
      pos_r[2] <= in_pos_z;
      base_r   <= row_i;
    end
  end

  // Read data stage tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_INFL);
    end
  end

  always_ff @(posedge clk) begin
    rd_k_r <= ik_r;
  end

  // Transform operand selection: row r of column c, hi then lo half.
  assign xr    = xj_r[2:1];
  assign x_idx = ({2'b0, xr} << 1) + {2'b0, xr} + {2'b0, xc_r};

  always_comb begin
    case (xr)
      2'd0:    x_pos = pos_r[0];
      2'd1:    x_pos = pos_r[1];
      2'd2:    x_pos = pos_r[2];
      default: x_pos = ONE_Q16;
    endcase
  end

  // Single composite read port, shared by both phases.
  assign comp_ridx = (state_r == ST_XFORM) ? x_idx : mul_tag.idx;
  assign comp_rd   = comp_r[comp_ridx];

  // Multiplier operand mux; the upper half of a composite word keeps its sign.
  always_comb begin
    mul_in_tag = '0;
    if (rd_vld_r) begin
      mul_in_vld     = 1'b1;
      mul_a          = rdata;
      mul_b          = MUL_B_W'(weight_r);
      mul_in_tag.idx = rd_k_r;
    end else begin
      mul_in_vld       = (state_r == ST_XFORM);
      mul_a            = x_pos;
      mul_b            = xj_r[0] ? $signed({1'b0, comp_rd[23:0]})
                                 : MUL_B_W'($signed(comp_rd[COMP_W-1:24]));
      mul_in_tag.xform = 1'b1;
      mul_in_tag.idx   = x_idx;
      mul_in_tag.comp  = xc_r;
      mul_in_tag.hi    = !xj_r[0];
      mul_in_tag.first = (xj_r == '0);
      mul_in_tag.last  = (xj_r == LAST_XSTEP);
    end
  end

  lbs_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (mul_in_vld),
    .a       (mul_a),
    .b       (mul_b),
    .in_tag  (mul_in_tag),
    .out_vld (mul_vld),
    .prod    (mul_p),
    .out_tag (mul_tag)
  );

  // Influence: composite word plus floor(product / 2^16), saturated to 48 bits.
  assign inf_sum = (COMP_W+2)'(comp_rd) + (COMP_W+2)'($signed(mul_p[MUL_P_W-1:16]));

  always_comb begin
    if (inf_sum[COMP_W+1:COMP_W-1] == 3'b000 || inf_sum[COMP_W+1:COMP_W-1] == 3'b111) begin
      inf_sat = inf_sum[COMP_W-1:0];
    end else if (inf_sum[COMP_W+1]) begin
      inf_sat = {1'b1, {(COMP_W-1){1'b0}}};
    end else begin
      inf_sat = {1'b0, {(COMP_W-1){1'b1}}};
    end
  end

  // Composite storage.
  always_ff @(posedge clk) begin
    if (!rst_n || clear_comp) begin
      for (int i = 0; i < NUM_COMP; i++) begin
        comp_r[i] <= '0;
      end
    end else if (mul_vld && !mul_tag.xform) begin
      comp_r[mul_tag.idx] <= inf_sat;
    end
  end

  // Transform accumulator: exact sum of all partial products.
  assign term    = mul_tag.hi ? (ACC_W'(mul_p) <<< 24) : ACC_W'(mul_p);
  assign acc_nxt = (mul_tag.first ? '0 : acc_r) + term;

  always_ff @(posedge clk) begin
    if (mul_vld && mul_tag.xform) begin
      acc_r <= acc_nxt;
    end
  end

  // Finish flag: the accumulator holds a complete column sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      fin_r     <= mul_vld && mul_tag.xform && mul_tag.last;
      out_vld_r <= fin_r && (fin_comp_r == LAST_COMP);
    end
  end

  always_ff @(posedge clk) begin
    fin_comp_r <= mul_tag.comp;
    if (fin_r) begin
      out_r[fin_comp_r] <= sat_q16(acc_r);
    end
  end

  assign pipe_busy = rd_vld_r || mul_vld || fin_r;

  // Result ports.
  assign out_valid = out_vld_r;
  assign out_x     = out_r[0];
  assign out_y     = out_r[1];
  assign out_z     = out_r[2];

endmodule

>>> rtl/lbs_checker.sv
// ----------------------------------------------------------------------------
// lbs_checker
// Port-level checks of the skinning unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_blend_skinning_unit_macros.svh"

module lbs_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_func,
  input logic out_valid
);
  import lbs_pkg::*;

  // A result strobe lasts exactly one cycle.
  `LBS_ASSERT_ON(a_strobe_pulse, out_valid |=> !out_valid, "result strobe held over one cycle")

  // A result only appears while a vertex transaction is in flight.
  `LBS_ASSERT_ON(a_strobe_busy, out_valid |-> busy, "result strobe while idle")

  // A palette write completes in its own cycle.
  `LBS_ASSERT_ON(a_write_fast, (start && !busy && (in_func == FUNC_WRITE)) |=> !busy,
    "palette write left the unit busy")

  // No result can follow an accepted transaction in the very next cycle.
  `LBS_ASSERT_ON(a_no_instant, (start && !busy) |=> !out_valid, "result too early")

  // Reset leaves the unit idle and quiet.
  `LBS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!busy && !out_valid), "not idle after reset")

endmodule

bind linear_blend_skinning_unit lbs_checker u_lbs_checker (.*);
